>>> rtl/hashed_byte_gram_count_table_assert.svh
// assertion macros for the hashed byte-gram counting table
// used by the top level only; expects clk and rst_n in scope
`ifndef HASHED_BYTE_GRAM_COUNT_TABLE_ASSERT_SVH
`define HASHED_BYTE_GRAM_COUNT_TABLE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HBGCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbgct assertion failed");

// next-cycle implication, disabled during reset
`define HBGCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbgct assertion failed");

`endif

>>> rtl/hbgct_pkg.sv
// shared types and constants for the hashed byte-gram counting table
// no dependencies
package hbgct_pkg;

    localparam int INDEX_BITS = 17;
    localparam int COUNT_BITS = 32;
    localparam int TABLE_DEPTH = 1 << INDEX_BITS;

    localparam logic [31:0] SEED_RESET = 32'd54334561;
    // lookup3 initial constant plus key length of 4
    localparam logic [31:0] LOOKUP3_INIT = 32'hDEADBEF3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] REQ_SPAM     = 2'd0;
    localparam logic [1:0] REQ_HAM      = 2'd1;
    localparam logic [1:0] REQ_CLASSIFY = 2'd2;

    typedef struct packed {
        logic [1:0]            req;
        logic [INDEX_BITS-1:0] idx;
    } work_item_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned k);
        return (v << k) | (v >> (32 - k));
    endfunction

endpackage

>>> rtl/hbgct_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module hbgct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/hbgct_fifo.sv
// two-entry queue of hashed work items between front and back
// depends on hbgct_pkg
module hbgct_fifo
    import hbgct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  work_item_t push_item,
    output logic       full,
    input  logic       pop,
    output work_item_t head_item,
    output logic       empty
);

    work_item_t  entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/hbgct_front.sv
// front end: takes input items, shifts the byte window and runs the lookup3 hash
// one mixing step per cycle; depends on hbgct_pkg
module hbgct_front
    import hbgct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_req,
    input  logic        in_start,
    input  logic [7:0]  in_byte,
    output logic        push,
    output work_item_t  push_item,
    input  logic        q_full
);

    typedef enum logic [3:0] {
        F_IDLE, F_INIT, F_KEY,
        F_MIX1, F_MIX2, F_MIX3, F_MIX4, F_MIX5, F_MIX6, F_MIX7,
        F_PUSH
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [31:0]  seed_reg, seed_next;
    logic [31:0]  window_reg, window_next;
    logic [1:0]   req_reg, req_next;
    logic [31:0]  a_reg, a_next;
    logic [31:0]  b_reg, b_next;
    logic [31:0]  c_reg, c_next;

    assign in_ready       = (state_reg == F_IDLE);
    assign push           = (state_reg == F_PUSH) && !q_full;
    assign push_item.req  = req_reg;
    assign push_item.idx  = c_reg[INDEX_BITS-1:0];

    always_comb
    begin
        state_next  = state_reg;
        seed_next   = cfg_wr_en ? cfg_wr_data : seed_reg;
        window_next = window_reg;
        req_next    = req_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    // message start drops the old bytes before the shift
                    window_next = (in_start ? 32'd0 : (window_reg << 8)) | {24'd0, in_byte};
                    req_next    = in_req;
                    state_next  = F_INIT;
                end
            end
            F_INIT:
            begin
                a_next     = LOOKUP3_INIT + seed_reg;
                b_next     = LOOKUP3_INIT + seed_reg;
                c_next     = LOOKUP3_INIT + seed_reg;
                state_next = F_KEY;
            end
            F_KEY:
            begin
                a_next     = a_reg + window_reg;
                state_next = F_MIX1;
            end
            F_MIX1:
            begin
                c_next     = (c_reg ^ b_reg) - rotl32(b_reg, 14);
                state_next = F_MIX2;
            end
            F_MIX2:
            begin
                a_next     = (a_reg ^ c_reg) - rotl32(c_reg, 11);
                state_next = F_MIX3;
            end
            F_MIX3:
            begin
                b_next     = (b_reg ^ a_reg) - rotl32(a_reg, 25);
                state_next = F_MIX4;
            end
            F_MIX4:
            begin
                c_next     = (c_reg ^ b_reg) - rotl32(b_reg, 16);
                state_next = F_MIX5;
            end
            F_MIX5:
            begin
                a_next     = (a_reg ^ c_reg) - rotl32(c_reg, 4);
                state_next = F_MIX6;
            end
            F_MIX6:
            begin
                b_next     = (b_reg ^ a_reg) - rotl32(a_reg, 14);
                state_next = F_MIX7;
            end
            F_MIX7:
            begin
                c_next     = (c_reg ^ b_reg) - rotl32(b_reg, 24);
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            seed_reg   <= SEED_RESET;
            window_reg <= 32'd0;
        end
        else
        begin
            state_reg  <= state_next;
            seed_reg   <= seed_next;
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
    end

endmodule

>>> rtl/hbgct_back.sv
// back end: clears both counter tables, then does the counter read-modify-write
// and holds the result item; depends on hbgct_pkg and hbgct_ram
module hbgct_back
    import hbgct_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  work_item_t   head_item,
    input  logic         q_empty,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [127:0] out_data
);

    typedef enum logic [1:0] {
        B_CLEAR, B_IDLE, B_UPDATE
    } back_state_t;

    back_state_t           state_reg, state_next;
    logic [INDEX_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [1:0]            req_reg;
    logic [COUNT_BITS-1:0] spam_total_reg, spam_total_next;
    logic [COUNT_BITS-1:0] ham_total_reg, ham_total_next;
    logic                  out_valid_reg, out_valid_next;
    logic [127:0]          out_data_reg, out_data_next;

    logic                  ram_we;
    logic [INDEX_BITS-1:0] ram_waddr;
    logic [COUNT_BITS-1:0] spam_wdata, ham_wdata;
    logic [COUNT_BITS-1:0] spam_rdata, ham_rdata;
    logic [COUNT_BITS-1:0] spam_new, ham_new;
    logic                  spam_inc, ham_inc;

    // pop only when the result register will be free by the update cycle
    assign pop = (state_reg == B_IDLE) && !q_empty && (!out_valid_reg || out_ready);

    assign spam_inc = (req_reg == REQ_SPAM) && (spam_rdata != COUNT_MAX);
    assign ham_inc  = (req_reg == REQ_HAM) && (ham_rdata != COUNT_MAX);
    assign spam_new = spam_rdata + COUNT_BITS'(spam_inc);
    assign ham_new  = ham_rdata + COUNT_BITS'(ham_inc);

    assign ram_we     = (state_reg == B_CLEAR) || (state_reg == B_UPDATE);
    assign ram_waddr  = (state_reg == B_CLEAR) ? clr_addr_reg : idx_reg;
    assign spam_wdata = (state_reg == B_CLEAR) ? '0 : spam_new;
    assign ham_wdata  = (state_reg == B_CLEAR) ? '0 : ham_new;

    hbgct_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_spam_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (spam_wdata),
        .raddr (head_item.idx),
        .rdata (spam_rdata)
    );

    hbgct_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ham_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ham_wdata),
        .raddr (head_item.idx),
        .rdata (ham_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        spam_total_next = spam_total_reg;
        ham_total_next  = ham_total_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + INDEX_BITS'(1);
                if (&clr_addr_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop)
                begin
                    state_next = B_UPDATE;
                end
            end
            B_UPDATE:
            begin
                // a total moves only with its counter
                if (spam_inc && (spam_total_reg != COUNT_MAX))
                begin
                    spam_total_next = spam_total_reg + COUNT_BITS'(1);
                end
                if (ham_inc && (ham_total_reg != COUNT_MAX))
                begin
                    ham_total_next = ham_total_reg + COUNT_BITS'(1);
                end
                out_valid_next = 1'b1;
                out_data_next  = {32'(ham_total_next), 32'(spam_total_next),
                                  32'(ham_new), 32'(spam_new)};
                state_next     = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_CLEAR;
            clr_addr_reg   <= '0;
            spam_total_reg <= '0;
            ham_total_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            spam_total_reg <= spam_total_next;
            ham_total_reg  <= ham_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (pop)
        begin
            idx_reg <= head_item.idx;
            req_reg <= head_item.req;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/hashed_byte_gram_count_table.sv
// top level: hashed byte-gram spam/ham counting table
// an accepted byte goes through the front end (init, key, mix steps, push), the queue, then the
// back end (pop with registered ram read, then update and write into the result register)
// the front end takes no new byte until it has pushed the last one, and the back end pops no new
// item until it has written the last; the front end's one-step-per-cycle lookup3 mix sets the pace
// reset: rst_n is asynchronous, active low; the tables are then swept to zero across all
// 131072 entries, during which inputs are queued but no result is produced
`include "hashed_byte_gram_count_table_assert.svh"

module hashed_byte_gram_count_table
    import hbgct_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // data_byte
    input  logic [2:0]   s_axis_tuser,  // req_type[1:0], msg_start[2]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // spam_hits[31:0], ham_hits[63:32], total_spam[95:64], total_ham[127:96]
    output logic [127:0] m_axis_tdata
);

    work_item_t push_item, head_item;
    logic       q_push, q_full, q_pop, q_empty;

    hbgct_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_req      (s_axis_tuser[1:0]),
        .in_start    (s_axis_tuser[2]),
        .in_byte     (s_axis_tdata),
        .push        (q_push),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    hbgct_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    hbgct_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    `HBGCT_ASSERT_NOW(a_no_push_when_full, q_push, !q_full)
    `HBGCT_ASSERT_NOW(a_no_pop_when_empty, q_pop, !q_empty)
    `HBGCT_ASSERT_NEXT(a_front_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

>>> verif/testbench.sv
// self-checking testbench for hashed_byte_gram_count_table
// keeps its own copy of the hashed spam/ham counting tables and checks every result item
// depends on rtl/hbgct_pkg.sv and the top level of the block
module testbench;
    import hbgct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES = 600;
    localparam int DIR_ROWS = 20;

    // spam_hits lowest, matching the packing of m_axis_tdata
    typedef struct packed {
        logic [31:0] total_ham;
        logic [31:0] total_spam;
        logic [31:0] ham_hits;
        logic [31:0] spam_hits;
    } gram_counts_t;

    typedef struct {
        logic [1:0]  req;
        logic        start;
        logic [7:0]  data;
        bit          typed;
        logic [31:0] spam;
        logic [31:0] ham;
        logic [31:0] tot_spam;
        logic [31:0] tot_ham;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata;   // data_byte
    logic [2:0] s_axis_tuser;   // req_type[1:0], msg_start[2]
    logic m_axis_tvalid;
    logic m_axis_tready;
    // spam_hits[31:0], ham_hits[63:32], total_spam[95:64], total_ham[127:96]
    logic [127:0] m_axis_tdata;

    // predictor state
    logic [31:0] hash_key;
    logic [31:0] gram_window;
    logic [31:0] spam_tbl [TABLE_DEPTH];
    logic [31:0] ham_tbl [TABLE_DEPTH];
    logic [31:0] spam_sum;
    logic [31:0] ham_sum;

    gram_counts_t pending_counts [$];
    dir_row_t dir_rows [DIR_ROWS];
    int unsigned faults = 0;
    bit src_gaps = 1'b0;
    bit allow_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    bit hold_pending = 1'b0;

    always #1 clk = ~clk;

    hashed_byte_gram_count_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic logic [31:0] rotl(input logic [31:0] v, input int k);
        logic [63:0] dbl;
        dbl = {v, v} << k;
        return dbl[63:32];
    endfunction

    // lookup3 final mix for a single 4-byte key
    function automatic logic [31:0] gram_hash(input logic [31:0] key, input logic [31:0] seed);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = LOOKUP3_INIT + seed;
        b = a;
        c = a;
        a = a + key;
        c = (c ^ b) - rotl(b, 14);
        a = (a ^ c) - rotl(c, 11);
        b = (b ^ a) - rotl(a, 25);
        c = (c ^ b) - rotl(b, 16);
        a = (a ^ c) - rotl(c, 4);
        b = (b ^ a) - rotl(a, 14);
        c = (c ^ b) - rotl(b, 24);
        return c;
    endfunction

    function automatic gram_counts_t count_gram(input logic [1:0] req, input logic start,
                                               input logic [7:0] data);
        logic [INDEX_BITS-1:0] slot;
        gram_counts_t r;
        if (start)
            gram_window = '0;
        gram_window = {gram_window[23:0], data};
        slot = INDEX_BITS'(gram_hash(gram_window, hash_key));
        // a total only moves when its counter really moved
        if (req == REQ_SPAM && spam_tbl[slot] != COUNT_MAX)
        begin
            spam_tbl[slot] = spam_tbl[slot] + 1;
            if (spam_sum != COUNT_MAX)
                spam_sum = spam_sum + 1;
        end
        else if (req == REQ_HAM && ham_tbl[slot] != COUNT_MAX)
        begin
            ham_tbl[slot] = ham_tbl[slot] + 1;
            if (ham_sum != COUNT_MAX)
                ham_sum = ham_sum + 1;
        end
        r.spam_hits = spam_tbl[slot];
        r.ham_hits = ham_tbl[slot];
        r.total_spam = spam_sum;
        r.total_ham = ham_sum;
        return r;
    endfunction

    task automatic offer_byte(input logic [1:0] req, input logic start, input logic [7:0] data);
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= {start, req};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic issue(input logic [1:0] req, input logic start, input logic [7:0] data);
        offer_byte(req, start, data);
        pending_counts.push_back(count_gram(req, start, data));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_seed(input logic [31:0] seed);
        cfg_wr_data <= seed;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        hash_key = seed;
    endtask

    // messages of random length; a narrow alphabet makes grams repeat so counts climb
    task automatic random_messages(input int n, input int hold_at);
        int sent;
        int len;
        bit narrow;
        bit mixed;
        bit broken;
        logic [1:0] kind;
        logic [1:0] req;
        logic [7:0] data;
        int pick;
        sent = 0;
        while (sent < n)
        begin
            len = $urandom_range(1, 12);
            narrow = $urandom_range(0, 1);
            mixed = ($urandom_range(0, 9) == 0);
            broken = ($urandom_range(0, 9) == 0);
            src_gaps = allow_gaps && ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 9);
            kind = (pick < 4) ? REQ_SPAM : (pick < 7) ? REQ_HAM :
                   (pick < 9) ? REQ_CLASSIFY : REQ_UNUSED;
            for (int i = 0; i < len && sent < n; i++)
            begin
                if (sent == hold_at)
                    hold_pending = 1'b1;
                data = narrow ? 8'h61 + 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
                req = mixed ? 2'($urandom_range(0, 3)) : kind;
                if ($urandom_range(0, 11) == 0)
                    issue(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
                else
                    issue(req, i == 0 && !broken, data);
                sent++;
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        gram_counts_t got;
        gram_counts_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_counts.size() == 0)
            begin
                $error("result item with nothing expected: %h", m_axis_tdata);
                faults++;
            end
            else
            begin
                want = pending_counts.pop_front();
                if (got.spam_hits !== want.spam_hits)
                begin
                    $error("spam_hits expected %0d got %0d", want.spam_hits, got.spam_hits);
                    faults++;
                end
                if (got.ham_hits !== want.ham_hits)
                begin
                    $error("ham_hits expected %0d got %0d", want.ham_hits, got.ham_hits);
                    faults++;
                end
                if (got.total_spam !== want.total_spam)
                begin
                    $error("total_spam expected %0d got %0d", want.total_spam, got.total_spam);
                    faults++;
                end
                if (got.total_ham !== want.total_ham)
                begin
                    $error("total_ham expected %0d got %0d", want.total_ham, got.total_ham);
                    faults++;
                end
            end
        end
    end

    // receiver side: random stall bursts, quiet stretches and one long hold-off
    initial
    begin : sink_side
        int unsigned sink_pct;
        int unsigned cyc;
        m_axis_tready <= 1'b0;
        sink_pct = 0;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 150 == 0)
                sink_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
            if (hold_pending)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 99) < sink_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("[hashed_byte_gram_count_table] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        gram_counts_t want;
        gram_counts_t typed_counts;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        hash_key = SEED_RESET;
        gram_window = '0;
        spam_sum = '0;
        ham_sum = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            spam_tbl[i] = '0;
            ham_tbl[i] = '0;
        end

        // zero bytes keep the window at zero, so the first rows all land on one slot
        dir_rows = '{
            '{REQ_CLASSIFY, 1'b1, 8'h00, 1'b1, 0, 0, 0, 0},
            '{REQ_SPAM,     1'b1, 8'h00, 1'b1, 1, 0, 1, 0},
            '{REQ_HAM,      1'b1, 8'h00, 1'b1, 1, 1, 1, 1},
            '{REQ_UNUSED,   1'b1, 8'h00, 1'b1, 1, 1, 1, 1},
            '{REQ_CLASSIFY, 1'b1, 8'h00, 1'b1, 1, 1, 1, 1},
            '{REQ_SPAM,     1'b0, 8'h00, 1'b1, 2, 1, 2, 1},
            '{REQ_HAM,      1'b0, 8'h00, 1'b1, 2, 2, 2, 2},
            '{REQ_SPAM,     1'b1, 8'hFF, 1'b0, 0, 0, 0, 0},
            '{REQ_SPAM,     1'b0, 8'hFF, 1'b0, 0, 0, 0, 0},
            '{REQ_SPAM,     1'b0, 8'hFF, 1'b0, 0, 0, 0, 0},
            '{REQ_SPAM,     1'b0, 8'hFF, 1'b0, 0, 0, 0, 0},
            '{REQ_HAM,      1'b0, 8'hFF, 1'b0, 0, 0, 0, 0},
            '{REQ_UNUSED,   1'b0, 8'hFF, 1'b0, 0, 0, 0, 0},
            '{REQ_CLASSIFY, 1'b1, 8'h00, 1'b0, 0, 0, 0, 0},
            '{REQ_HAM,      1'b1, 8'h80, 1'b0, 0, 0, 0, 0},
            '{REQ_SPAM,     1'b0, 8'h01, 1'b0, 0, 0, 0, 0},
            '{REQ_CLASSIFY, 1'b0, 8'h7F, 1'b0, 0, 0, 0, 0},
            '{REQ_HAM,      1'b0, 8'hAA, 1'b0, 0, 0, 0, 0},
            '{REQ_SPAM,     1'b0, 8'h55, 1'b0, 0, 0, 0, 0},
            '{REQ_UNUSED,   1'b1, 8'hFE, 1'b0, 0, 0, 0, 0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // items queue up while the tables are swept after reset
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            offer_byte(dir_rows[i].req, dir_rows[i].start, dir_rows[i].data);
            want = count_gram(dir_rows[i].req, dir_rows[i].start, dir_rows[i].data);
            if (dir_rows[i].typed)
            begin
                typed_counts.spam_hits = dir_rows[i].spam;
                typed_counts.ham_hits = dir_rows[i].ham;
                typed_counts.total_spam = dir_rows[i].tot_spam;
                typed_counts.total_ham = dir_rows[i].tot_ham;
                pending_counts.push_back(typed_counts);
            end
            else
                pending_counts.push_back(want);
        end

        random_messages(230, 100);
        drain_results();
        load_seed(32'h0000_0000);
        random_messages(200, -1);
        drain_results();
        load_seed(32'hFFFF_FFFF);
        random_messages(200, -1);
        drain_results();
        load_seed($urandom);
        random_messages(200, -1);
        drain_results();
        load_seed(SEED_RESET);
        allow_gaps = 1'b0;
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        random_messages(200, -1);
        drain_results();

        if (faults == 0 && pending_counts.size() == 0)
            $display("[hashed_byte_gram_count_table] OK");
        else
            $display("[hashed_byte_gram_count_table] ERROR");
        $finish;
    end

endmodule
